[design/ddpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpu_pkg: shared types and constants for the pose update block
// Holds the item structs, the configuration register indexes, the controller
// states and commands, and the constant tables of the arithmetic.
// ----------------------------------------------------------------------------
package ddpu_pkg;

    // One input item: one time step.
    typedef struct packed {
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic [15:0]        step_length;
        logic               load_pose;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic [15:0]        new_heading;
        logic               take_travel;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        pose_heading;
        logic [47:0]        elapsed;
        logic signed [31:0] travel_left;
        logic signed [31:0] travel_right;
        logic               saturated;
    } out_item_t;

    // Configuration register indexes.
    localparam int          CFG_IDX_W      = 8;
    localparam logic [7:0]  CFG_OFFSET_ONE = 8'd0;
    localparam logic [7:0]  CFG_OFFSET_TWO = 8'd1;
    localparam logic [23:0] OFFSET_RESET   = 24'd65536;

    // 2^32 / (2*pi) in Q32, and the CORDIC start gain in Q30.
    localparam logic [29:0]        TURN_PER_RAD = 30'd683565276;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_MDT, ST_QDIV, ST_TLO, ST_THI, ST_TURN, ST_NUM1, ST_NUM2,
        ST_C0INIT, ST_C0RUN, ST_C0END, ST_VSTART, ST_VDIV, ST_VMUL,
        ST_RSTART, ST_RDIV, ST_C1INIT, ST_C1RUN, ST_C1END,
        ST_XLO, ST_XHI, ST_XFIN, ST_YLO, ST_YHI, ST_YFIN, ST_TL, ST_TR, ST_FIN
    } state_t;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_MDT, OP_DIV, OP_TLO, OP_THI, OP_TURN,
        OP_NUM1, OP_NUM2, OP_C0INIT, OP_C1INIT, OP_CSTEP, OP_C0END, OP_C1END,
        OP_VSTART, OP_RSTART, OP_VMUL, OP_XLO, OP_XHI, OP_XFIN,
        OP_YLO, OP_YHI, OP_YFIN, OP_TL, OP_TR, OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic cor_last;
        logic straight;
    } stat_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[design/ddpu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpu_ctrl: sequencer of the pose update
// Walks each item through the multiply, divide and CORDIC steps of the
// datapath and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ddpu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ddpu_pkg::stat_t  stat,
    output ddpu_pkg::cmd_t   cmd
);

    ddpu_pkg::state_t state_reg;
    ddpu_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    // The output register can take a new item when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddpu_pkg::ST_IDLE:   if (in_valid) state_next = ddpu_pkg::ST_MDT;
            ddpu_pkg::ST_MDT:    state_next = ddpu_pkg::ST_QDIV;
            ddpu_pkg::ST_QDIV:   if (stat.div_last) state_next = ddpu_pkg::ST_TLO;
            ddpu_pkg::ST_TLO:    state_next = ddpu_pkg::ST_THI;
            ddpu_pkg::ST_THI:    state_next = ddpu_pkg::ST_TURN;
            ddpu_pkg::ST_TURN:   state_next = ddpu_pkg::ST_NUM1;
            ddpu_pkg::ST_NUM1:   state_next = ddpu_pkg::ST_NUM2;
            ddpu_pkg::ST_NUM2:   state_next = ddpu_pkg::ST_C0INIT;
            ddpu_pkg::ST_C0INIT: state_next = ddpu_pkg::ST_C0RUN;
            ddpu_pkg::ST_C0RUN:  if (stat.cor_last) state_next = ddpu_pkg::ST_C0END;
            ddpu_pkg::ST_C0END:
            begin
                if (stat.straight)
                    state_next = ddpu_pkg::ST_VSTART;
                else
                    state_next = ddpu_pkg::ST_RSTART;
            end
            ddpu_pkg::ST_VSTART: state_next = ddpu_pkg::ST_VDIV;
            ddpu_pkg::ST_VDIV:   if (stat.div_last) state_next = ddpu_pkg::ST_VMUL;
            ddpu_pkg::ST_VMUL:   state_next = ddpu_pkg::ST_XLO;
            ddpu_pkg::ST_RSTART: state_next = ddpu_pkg::ST_RDIV;
            ddpu_pkg::ST_RDIV:   if (stat.div_last) state_next = ddpu_pkg::ST_C1INIT;
            ddpu_pkg::ST_C1INIT: state_next = ddpu_pkg::ST_C1RUN;
            ddpu_pkg::ST_C1RUN:  if (stat.cor_last) state_next = ddpu_pkg::ST_C1END;
            ddpu_pkg::ST_C1END:  state_next = ddpu_pkg::ST_XLO;
            ddpu_pkg::ST_XLO:    state_next = ddpu_pkg::ST_XHI;
            ddpu_pkg::ST_XHI:    state_next = ddpu_pkg::ST_XFIN;
            ddpu_pkg::ST_XFIN:   state_next = ddpu_pkg::ST_YLO;
            ddpu_pkg::ST_YLO:    state_next = ddpu_pkg::ST_YHI;
            ddpu_pkg::ST_YHI:    state_next = ddpu_pkg::ST_YFIN;
            ddpu_pkg::ST_YFIN:   state_next = ddpu_pkg::ST_TL;
            ddpu_pkg::ST_TL:     state_next = ddpu_pkg::ST_TR;
            ddpu_pkg::ST_TR:     state_next = ddpu_pkg::ST_FIN;
            ddpu_pkg::ST_FIN:    if (slot_free) state_next = ddpu_pkg::ST_IDLE;
            default:             state_next = ddpu_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb
    begin
        cmd.op         = ddpu_pkg::OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ddpu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = ddpu_pkg::OP_ACCEPT;
            end
            ddpu_pkg::ST_MDT:    cmd.op = ddpu_pkg::OP_MDT;
            ddpu_pkg::ST_QDIV:   cmd.op = ddpu_pkg::OP_DIV;
            ddpu_pkg::ST_TLO:    cmd.op = ddpu_pkg::OP_TLO;
            ddpu_pkg::ST_THI:    cmd.op = ddpu_pkg::OP_THI;
            ddpu_pkg::ST_TURN:   cmd.op = ddpu_pkg::OP_TURN;
            ddpu_pkg::ST_NUM1:   cmd.op = ddpu_pkg::OP_NUM1;
            ddpu_pkg::ST_NUM2:   cmd.op = ddpu_pkg::OP_NUM2;
            ddpu_pkg::ST_C0INIT: cmd.op = ddpu_pkg::OP_C0INIT;
            ddpu_pkg::ST_C0RUN:  cmd.op = ddpu_pkg::OP_CSTEP;
            ddpu_pkg::ST_C0END:  cmd.op = ddpu_pkg::OP_C0END;
            ddpu_pkg::ST_VSTART: cmd.op = ddpu_pkg::OP_VSTART;
            ddpu_pkg::ST_VDIV:   cmd.op = ddpu_pkg::OP_DIV;
            ddpu_pkg::ST_VMUL:   cmd.op = ddpu_pkg::OP_VMUL;
            ddpu_pkg::ST_RSTART: cmd.op = ddpu_pkg::OP_RSTART;
            ddpu_pkg::ST_RDIV:   cmd.op = ddpu_pkg::OP_DIV;
            ddpu_pkg::ST_C1INIT: cmd.op = ddpu_pkg::OP_C1INIT;
            ddpu_pkg::ST_C1RUN:  cmd.op = ddpu_pkg::OP_CSTEP;
            ddpu_pkg::ST_C1END:  cmd.op = ddpu_pkg::OP_C1END;
            ddpu_pkg::ST_XLO:    cmd.op = ddpu_pkg::OP_XLO;
            ddpu_pkg::ST_XHI:    cmd.op = ddpu_pkg::OP_XHI;
            ddpu_pkg::ST_XFIN:   cmd.op = ddpu_pkg::OP_XFIN;
            ddpu_pkg::ST_YLO:    cmd.op = ddpu_pkg::OP_YLO;
            ddpu_pkg::ST_YHI:    cmd.op = ddpu_pkg::OP_YHI;
            ddpu_pkg::ST_YFIN:   cmd.op = ddpu_pkg::OP_YFIN;
            ddpu_pkg::ST_TL:     cmd.op = ddpu_pkg::OP_TL;
            ddpu_pkg::ST_TR:     cmd.op = ddpu_pkg::OP_TR;
            ddpu_pkg::ST_FIN:
            begin
                if (slot_free)
                begin
                    cmd.op         = ddpu_pkg::OP_FIN;
                    out_valid_next = 1'b1;
                end
            end
            default:             cmd.op = ddpu_pkg::OP_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddpu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/ddpu_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpu_dpath: arithmetic of the pose update
// One shared signed multiplier, a one-bit-per-cycle restoring divider, an
// iterative CORDIC rotator, the pose and travel state and the output register.
// ----------------------------------------------------------------------------
module ddpu_dpath
#(
    parameter int CORDIC_ROUNDS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddpu_pkg::cmd_t        cmd,
    output ddpu_pkg::stat_t       stat,
    input  ddpu_pkg::in_item_t    in_item,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    output ddpu_pkg::out_item_t   out_item
);

    localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

    // Rounds a signed value by 2^16, half away from zero.
    function automatic logic signed [33:0] rnd16(input logic signed [48:0] v);
        logic [48:0]        mg;
        logic [48:0]        rs;
        logic signed [33:0] r;
        mg = v[48] ? 49'(-v) : 49'(v);
        rs = (mg + 49'd32768) >> 16;
        r  = $signed({1'b0, rs[32:0]});
        if (v[48])
            r = -r;
        return r;
    endfunction

    // Clips to 32 bits signed; the top bit flags a clip.
    function automatic logic [32:0] sat32(input logic signed [49:0] v);
        logic [32:0] r;
        if (v > S32_MAX)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < S32_MIN)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    // Magnitude of a multiplier operand, capped at 2^32-1.
    function automatic logic [31:0] cap32(input logic signed [34:0] b);
        logic [34:0] m;
        m = b[34] ? 35'(-b) : 35'(b);
        return (m[34:32] != 3'd0) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    // Combines the partial products into a rounded Q30 step, capped at 2^40.
    function automatic logic signed [41:0] q30fin(input logic [56:0] hi,
                                                  input logic [63:0] lo,
                                                  input logic neg);
        logic [88:0]        p;
        logic [61:0]        sm;
        logic [40:0]        r;
        logic signed [41:0] d;
        p  = {hi, 32'd0} + {25'd0, lo};
        sm = {1'b0, p[60:0]} + (62'd1 << 29);
        if (p[88:61] != 28'd0)
            r = 41'd1 << 40;
        else
            r = {9'd0, sm[61:30]};
        d = $signed({1'b0, r});
        if (neg)
            d = -d;
        return d;
    endfunction

    // Configuration and pose state.
    logic [23:0]        o1_reg, o2_reg;
    logic signed [31:0] px_reg, py_reg, tl_reg, tr_reg;
    logic [15:0]        hd_reg;
    logic [47:0]        time_reg;

    // Per-item working registers.
    logic signed [31:0] vl_reg, vr_reg;
    logic [15:0]        dt_reg;
    logic               take_reg;
    logic signed [32:0] dv_reg;
    logic [24:0]        den_reg;
    logic [63:0]        qd_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        dvsr_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        lo_reg;
    logic [56:0]        hi_reg;
    logic [31:0]        t_reg;
    logic               qhi_nz_reg;
    logic [31:0]        th1_reg;
    logic               straight_reg;
    logic signed [56:0] num_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] c0_reg, s0_reg;
    logic [56:0]        ma_reg;
    logic               sa_reg;
    logic signed [34:0] mbx_reg, mby_reg;
    logic signed [31:0] nx_reg, ny_reg, ntl_reg, ntr_reg;
    logic               sat_reg;
    ddpu_pkg::out_item_t out_reg;

    // Derived values.
    logic [31:0]        dv_mag;
    logic [56:0]        num_mag;
    logic signed [33:0] vc_s;
    logic [31:0]        cap_sel;
    logic [31:0]        th0;

    assign dv_mag  = dv_reg[32] ? 32'(-dv_reg) : 32'(dv_reg);
    assign num_mag = num_reg[56] ? 57'(-num_reg) : 57'(num_reg);
    assign vc_s    = num_reg[56] ? -$signed({1'b0, qd_reg[32:0]})
                                 : $signed({1'b0, qd_reg[32:0]});
    assign th0     = {hd_reg, 16'd0};

    always_comb
    begin
        case (cmd.op)
            ddpu_pkg::OP_YLO, ddpu_pkg::OP_YHI: cap_sel = cap32(mby_reg);
            default:                            cap_sel = cap32(mbx_reg);
        endcase
    end

    // Shared multiplier operand select.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ddpu_pkg::OP_MDT:
            begin
                mul_a = $signed({2'd0, dv_mag});
                mul_b = $signed({18'd0, dt_reg});
            end
            ddpu_pkg::OP_TLO:
            begin
                mul_a = $signed({2'd0, qd_reg[31:0]});
                mul_b = $signed({4'd0, ddpu_pkg::TURN_PER_RAD});
            end
            ddpu_pkg::OP_THI:
            begin
                mul_a = $signed({2'd0, qd_reg[63:32]});
                mul_b = $signed({4'd0, ddpu_pkg::TURN_PER_RAD});
            end
            ddpu_pkg::OP_NUM1:
            begin
                mul_a = 34'(vl_reg);
                mul_b = $signed({10'd0, o2_reg});
            end
            ddpu_pkg::OP_NUM2:
            begin
                mul_a = 34'(vr_reg);
                mul_b = $signed({10'd0, o1_reg});
            end
            ddpu_pkg::OP_VMUL:
            begin
                mul_a = vc_s;
                mul_b = $signed({18'd0, dt_reg});
            end
            ddpu_pkg::OP_XLO, ddpu_pkg::OP_YLO:
            begin
                mul_a = $signed({2'd0, ma_reg[31:0]});
                mul_b = $signed({2'd0, cap_sel});
            end
            ddpu_pkg::OP_XHI, ddpu_pkg::OP_YHI:
            begin
                mul_a = $signed({9'd0, ma_reg[56:32]});
                mul_b = $signed({2'd0, cap_sel});
            end
            ddpu_pkg::OP_TL:
            begin
                mul_a = 34'(vl_reg);
                mul_b = $signed({18'd0, dt_reg});
            end
            ddpu_pkg::OP_TR:
            begin
                mul_a = 34'(vr_reg);
                mul_b = $signed({18'd0, dt_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Restoring divider step.
    logic [33:0] rem_sh;
    logic        div_ge;
    logic [33:0] rem_diff;

    assign rem_sh   = {rem_reg, qd_reg[63]};
    assign div_ge   = rem_sh >= {1'b0, dvsr_reg};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};

    // Turn rounding and heading.
    logic [31:0] t_next;
    logic [31:0] turn;

    assign t_next = prod[31:0] + lo_reg[63:32] + {31'd0, lo_reg[31]};
    assign turn   = dv_reg[32] ? (32'd0 - t_reg) : t_reg;

    // CORDIC angle fold and rotation step.
    logic [31:0]        ang;
    logic [31:0]        ang_bias;
    logic [1:0]         quad_next;
    logic [31:0]        z0;
    logic signed [32:0] sh_x, sh_y, atan_e;

    assign ang       = (cmd.op == ddpu_pkg::OP_C0INIT) ? th0 : th1_reg;
    assign ang_bias  = ang + 32'h2000_0000;
    assign quad_next = ang_bias[31:30];
    assign z0        = ang - {quad_next, 30'd0};
    assign sh_x      = cx_reg >>> cnt_reg[4:0];
    assign sh_y      = cy_reg >>> cnt_reg[4:0];
    assign atan_e    = $signed({1'b0, ddpu_pkg::atan_bam(cnt_reg[4:0])});

    // Quadrant mapping of the rotator output.
    logic signed [33:0] cs_c, cs_s, xe, ye;

    assign xe = 34'(cx_reg);
    assign ye = 34'(cy_reg);

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cs_c = xe;
                cs_s = ye;
            end
            2'd1:
            begin
                cs_c = -ye;
                cs_s = xe;
            end
            2'd2:
            begin
                cs_c = -xe;
                cs_s = -ye;
            end
            default:
            begin
                cs_c = ye;
                cs_s = -xe;
            end
        endcase
    end

    // Position, travel and time updates.
    logic signed [41:0] dstep;
    logic [32:0]        pos_sat;
    logic signed [33:0] trav_step;
    logic [32:0]        trav_sat;
    logic [48:0]        time_sum;
    logic [47:0]        time_new;
    logic [31:0]        th1_rnd;

    always_comb
    begin
        dstep = q30fin(hi_reg, lo_reg,
                       sa_reg ^ ((cmd.op == ddpu_pkg::OP_YFIN) ? mby_reg[34] : mbx_reg[34]));
        if (cmd.op == ddpu_pkg::OP_YFIN)
            pos_sat = sat32(50'(py_reg) + 50'(dstep));
        else
            pos_sat = sat32(50'(px_reg) + 50'(dstep));
        trav_step = rnd16(prod[48:0]);
        if (cmd.op == ddpu_pkg::OP_TR)
            trav_sat = sat32(50'(tr_reg) + 50'(trav_step));
        else
            trav_sat = sat32(50'(tl_reg) + 50'(trav_step));
    end

    assign time_sum = {1'b0, time_reg} + {33'd0, dt_reg};
    assign time_new = time_sum[48] ? 48'hFFFF_FFFF_FFFF : time_sum[47:0];
    assign th1_rnd  = th1_reg + 32'h0000_8000;

    // Configuration and pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_reg   <= ddpu_pkg::OFFSET_RESET;
            o2_reg   <= ddpu_pkg::OFFSET_RESET;
            px_reg   <= '0;
            py_reg   <= '0;
            hd_reg   <= '0;
            time_reg <= '0;
            tl_reg   <= '0;
            tr_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ddpu_pkg::CFG_OFFSET_ONE: o1_reg <= cfg_data;
                    ddpu_pkg::CFG_OFFSET_TWO: o2_reg <= cfg_data;
                    default:                  o1_reg <= o1_reg;
                endcase
            end
            case (cmd.op)
                ddpu_pkg::OP_ACCEPT:
                begin
                    if (in_item.load_pose)
                    begin
                        px_reg <= in_item.new_x;
                        py_reg <= in_item.new_y;
                        hd_reg <= in_item.new_heading;
                    end
                end
                ddpu_pkg::OP_FIN:
                begin
                    px_reg   <= nx_reg;
                    py_reg   <= ny_reg;
                    hd_reg   <= th1_rnd[31:16];
                    time_reg <= time_new;
                    tl_reg   <= take_reg ? 32'sd0 : ntl_reg;
                    tr_reg   <= take_reg ? 32'sd0 : ntr_reg;
                end
                default:
                begin
                    px_reg <= px_reg;
                end
            endcase
        end
    end

    // Working registers, stepped by the controller's commands.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ddpu_pkg::OP_ACCEPT:
            begin
                vl_reg   <= in_item.left_speed;
                vr_reg   <= in_item.right_speed;
                dt_reg   <= in_item.step_length;
                take_reg <= in_item.take_travel;
                dv_reg   <= 33'(in_item.right_speed) - 33'(in_item.left_speed);
                if (({1'b0, o1_reg} + {1'b0, o2_reg}) == 25'd0)
                    den_reg <= 25'd1;
                else
                    den_reg <= {1'b0, o1_reg} + {1'b0, o2_reg};
                sat_reg  <= 1'b0;
            end
            ddpu_pkg::OP_MDT:
            begin
                qd_reg   <= {prod[47:0], 16'd0};
                rem_reg  <= '0;
                dvsr_reg <= {8'd0, den_reg};
                cnt_reg  <= '0;
            end
            ddpu_pkg::OP_VSTART:
            begin
                qd_reg   <= {7'd0, num_mag};
                rem_reg  <= '0;
                dvsr_reg <= {8'd0, den_reg};
                cnt_reg  <= '0;
            end
            ddpu_pkg::OP_RSTART:
            begin
                qd_reg   <= {7'd0, num_mag};
                rem_reg  <= '0;
                dvsr_reg <= {1'b0, dv_mag};
                cnt_reg  <= '0;
            end
            ddpu_pkg::OP_DIV:
            begin
                rem_reg <= div_ge ? rem_diff[32:0] : rem_sh[32:0];
                qd_reg  <= {qd_reg[62:0], div_ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            ddpu_pkg::OP_TLO:
            begin
                lo_reg <= prod[63:0];
            end
            ddpu_pkg::OP_THI:
            begin
                t_reg      <= t_next;
                qhi_nz_reg <= qd_reg[63:32] != 32'd0;
            end
            ddpu_pkg::OP_TURN:
            begin
                th1_reg      <= th0 + turn;
                straight_reg <= (t_reg == 32'd0) && !qhi_nz_reg;
            end
            ddpu_pkg::OP_NUM1:
            begin
                num_reg <= prod[56:0];
            end
            ddpu_pkg::OP_NUM2:
            begin
                num_reg <= num_reg + prod[56:0];
            end
            ddpu_pkg::OP_C0INIT, ddpu_pkg::OP_C1INIT:
            begin
                quad_reg <= quad_next;
                cz_reg   <= 33'($signed(z0));
                cx_reg   <= ddpu_pkg::CORDIC_GAIN;
                cy_reg   <= '0;
                cnt_reg  <= '0;
            end
            ddpu_pkg::OP_CSTEP:
            begin
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_e;
                end
                else
                begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_e;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            ddpu_pkg::OP_C0END:
            begin
                c0_reg <= cs_c;
                s0_reg <= cs_s;
            end
            ddpu_pkg::OP_C1END:
            begin
                ma_reg  <= qd_reg[56:0];
                sa_reg  <= num_reg[56] ^ dv_reg[32];
                mbx_reg <= 35'(cs_s) - 35'(s0_reg);
                mby_reg <= 35'(c0_reg) - 35'(cs_c);
            end
            ddpu_pkg::OP_VMUL:
            begin
                ma_reg  <= {25'd0, 32'(rnd16(prod[48:0]) < 0 ? -rnd16(prod[48:0])
                                                            : rnd16(prod[48:0]))};
                sa_reg  <= num_reg[56];
                mbx_reg <= 35'(c0_reg);
                mby_reg <= 35'(s0_reg);
            end
            ddpu_pkg::OP_XLO, ddpu_pkg::OP_YLO:
            begin
                lo_reg <= prod[63:0];
            end
            ddpu_pkg::OP_XHI, ddpu_pkg::OP_YHI:
            begin
                hi_reg <= prod[56:0];
            end
            ddpu_pkg::OP_XFIN:
            begin
                nx_reg  <= pos_sat[31:0];
                sat_reg <= sat_reg | pos_sat[32];
            end
            ddpu_pkg::OP_YFIN:
            begin
                ny_reg  <= pos_sat[31:0];
                sat_reg <= sat_reg | pos_sat[32];
            end
            ddpu_pkg::OP_TL:
            begin
                ntl_reg <= trav_sat[31:0];
                sat_reg <= sat_reg | trav_sat[32];
            end
            ddpu_pkg::OP_TR:
            begin
                ntr_reg <= trav_sat[31:0];
                sat_reg <= sat_reg | trav_sat[32];
            end
            ddpu_pkg::OP_FIN:
            begin
                out_reg.pose_x       <= nx_reg;
                out_reg.pose_y       <= ny_reg;
                out_reg.pose_heading <= th1_rnd[31:16];
                out_reg.elapsed      <= time_new;
                out_reg.travel_left  <= take_reg ? ntl_reg : 32'sd0;
                out_reg.travel_right <= take_reg ? ntr_reg : 32'sd0;
                out_reg.saturated    <= sat_reg | time_sum[48];
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Status to the controller.
    assign stat.div_last = cnt_reg == 6'd63;
    assign stat.cor_last = cnt_reg == 6'(CORDIC_ROUNDS - 1);
    assign stat.straight = straight_reg;

    assign out_item = out_reg;

endmodule

[design/differential_drive_pose_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_pose_update: odometry pose update for a two-wheel base
// Each input item is one time step; each produces exactly one result item.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one time step (wheel speeds, step length and an
//   optional pose load). out_valid/out_ready return the updated pose, the
//   elapsed time and, when asked for, the accumulated wheel travel.
//   cfg_valid/cfg_ready write offset_one (index 0) or offset_two (index 1);
//   cfg_ready is always high and writes belong between items.
// Sequencing:
//   One item is worked at a time. The sequencer is idle and ready for the
//   next item in the same cycle that a result becomes valid. The work of an
//   item is set by the one-bit-per-cycle divider, run twice per item over
//   64 quotient bits, and by the CORDIC rotator, run once when the step is
//   straight and twice when it turns.
// Reset and stalls:
//   Reset clears the pose, time and travel and sets both offsets to 1.0.
//   The result waits in an output register while the receiver stalls; the
//   next item is accepted meanwhile and holds at its final step until the
//   register frees.
// ----------------------------------------------------------------------------
module differential_drive_pose_update
#(
    parameter int CORDIC_ROUNDS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ddpu_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ddpu_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [23:0]          cfg_data
);

    ddpu_pkg::cmd_t  cmd;
    ddpu_pkg::stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    ddpu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ddpu_dpath #(
        .CORDIC_ROUNDS (CORDIC_ROUNDS)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

[design/ddpu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpu_checker: port-level checks of the pose update
// Watches the handshakes of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
module ddpu_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ddpu_pkg::out_item_t out_item
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // One item at a time: busy right after an acceptance.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after acceptance");

    // A result never appears the cycle after acceptance.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // A new result returns the sequencer to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("sequencer not idle after result");

    // No result during reset.
    a_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid in reset");

endmodule

bind differential_drive_pose_update ddpu_checker u_ddpu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the differential-drive pose update block
// A driver feeds time steps from a queue with random gaps, a monitor takes
// results with random stalls, and a bit-accurate odometry model predicts
// every result field. The offsets are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROUNDS = 16;
    localparam longint M32 = 64'hFFFF_FFFF;
    localparam longint STEP_LIMIT = 64'sd1 << 40;
    localparam longint TIME_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint KTURN = 64'd683565276;
    localparam longint KGAIN = 64'd652032874;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ddpu_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ddpu_pkg::out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = ddpu_pkg::CFG_OFFSET_ONE;
    logic [23:0] cfg_data = '0;

    // Model state: pose, time, travel and the two wheel offsets.
    longint m_x, m_y, m_left, m_right;
    longint unsigned m_time;
    logic [15:0] m_head;
    longint unsigned m_off1 = 65536, m_off2 = 65536;

    ddpu_pkg::in_item_t step_queue[$];
    ddpu_pkg::out_item_t pose_queue[$];
    int errors = 0;
    int n_results = 0;
    int n_turns = 0;
    int n_sat = 0;
    bit hold = 1'b0;

    differential_drive_pose_update #(.CORDIC_ROUNDS(ROUNDS)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned magn(longint v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    // Shift down with rounding half away from zero.
    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (magn(v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint trunc_div(longint n, longint d);
        longint unsigned q;
        q = magn(n) / magn(d);
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] arctan_angle(int i);
        logic [31:0] t[32] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10680862, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
            326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    // Position step a*b/2^30, rounded, magnitude clipped to 2^40.
    function automatic longint scale_q30(longint a, longint b);
        longint unsigned ma, mb, plo, phi, t, r;
        ma = magn(a);
        mb = magn(b);
        if (mb > M32) mb = M32;
        plo = (ma & M32) * mb;
        phi = (ma >> 32) * mb + (plo >> 32);
        if (phi >= (64'd1 << 29)) r = STEP_LIMIT;
        else
        begin
            t = (phi << 32) | (plo & M32);
            r = (t + (64'd1 << 29)) >> 30;
            if (r > STEP_LIMIT) r = STEP_LIMIT;
        end
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Rotator: fold to the nearest axis, then ROUNDS shift-add rotations.
    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [1:0] quad;
        logic [31:0] za;
        longint z, x, y, nx;
        quad = 2'((ang + 32'h2000_0000) >> 30);
        za = ang - ({30'd0, quad} << 30);
        z = longint'(signed'(za));
        x = KGAIN;
        y = 0;
        for (int i = 0; i < ROUNDS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_angle(i);
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_angle(i);
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint clip32(longint v, ref bit f);
        if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
        return v;
    endfunction

    // Advance the odometry by one time step and return the expected pose.
    function automatic ddpu_pkg::out_item_t odometry_step(ddpu_pkg::in_item_t it);
        ddpu_pkg::out_item_t r;
        longint vl, vr, dv, num, dx, dy, c0, s0, c1, s1, vc, sd, rad;
        longint unsigned dt, den, q, lo, mid, t;
        logic [31:0] turn, th0, th1;
        bit sat;
        vl = longint'(it.left_speed);
        vr = longint'(it.right_speed);
        dt = it.step_length;
        den = m_off1 + m_off2;
        sat = 0;
        if (it.load_pose)
        begin
            m_x = longint'(it.new_x);
            m_y = longint'(it.new_y);
            m_head = it.new_heading;
        end
        if (den == 0) den = 1;
        dv = vr - vl;
        q = ((magn(dv) * dt) << 16) / den;
        lo = (q & M32) * KTURN;
        mid = (q >> 32) * KTURN + (lo >> 32);
        t = (mid + (((lo & M32) + (64'd1 << 31)) >> 32)) & M32;
        turn = dv < 0 ? 32'(64'd0 - t) : 32'(t);
        th0 = {m_head, 16'd0};
        th1 = th0 + turn;
        sin_cos(th0, c0, s0);
        num = vl * longint'(m_off2) + vr * longint'(m_off1);
        if (t == 0 && (q >> 32) == 0)
        begin
            vc = trunc_div(num, longint'(den));
            sd = round_shift(vc * longint'(dt), 16);
            dx = scale_q30(sd, c0);
            dy = scale_q30(sd, s0);
        end
        else
        begin
            n_turns++;
            rad = (dv != 0) ? trunc_div(num, dv) : 0;
            sin_cos(th1, c1, s1);
            dx = scale_q30(rad, s1 - s0);
            dy = scale_q30(rad, c0 - c1);
        end
        m_x = clip32(m_x + dx, sat);
        m_y = clip32(m_y + dy, sat);
        m_head = 16'((th1 + 32'h8000) >> 16);
        m_time += dt;
        if (m_time > TIME_MAX)
        begin
            m_time = TIME_MAX;
            sat = 1;
        end
        m_left = clip32(m_left + round_shift(vl * longint'(dt), 16), sat);
        m_right = clip32(m_right + round_shift(vr * longint'(dt), 16), sat);
        r.pose_x = m_x[31:0];
        r.pose_y = m_y[31:0];
        r.pose_heading = m_head;
        r.elapsed = m_time[47:0];
        if (it.take_travel)
        begin
            r.travel_left = m_left[31:0];
            r.travel_right = m_right[31:0];
            m_left = 0;
            m_right = 0;
        end
        else
        begin
            r.travel_left = '0;
            r.travel_right = '0;
        end
        r.saturated = sat;
        return r;
    endfunction

    // Driver: one item from the queue at a time, with a random gap before each.
    int gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pose_queue.push_back(odometry_step(in_item));
            void'(step_queue.pop_front());
            gap <= $urandom_range(0, 4);
            in_valid <= 1'b0;
        end
        else if (!in_valid && rst_n && !hold && step_queue.size() > 0)
        begin
            if (gap > 0) gap <= gap - 1;
            else
            begin
                in_item <= step_queue[0];
                in_valid <= 1'b1;
            end
        end
    end

    // Monitor: random stalls on the result side, compare each field.
    int stall = 0;
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            n_results++;
            if (pose_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, out_item);
            end
            else
            begin
                ddpu_pkg::out_item_t e;
                e = pose_queue.pop_front();
                if (e.saturated) n_sat++;
                if (e.pose_x !== out_item.pose_x ||
                    e.pose_y !== out_item.pose_y ||
                    e.pose_heading !== out_item.pose_heading ||
                    e.elapsed !== out_item.elapsed ||
                    e.travel_left !== out_item.travel_left ||
                    e.travel_right !== out_item.travel_right ||
                    e.saturated !== out_item.saturated)
                begin
                    errors++;
                    $display("%0t: mismatch expected x=%h y=%h h=%h t=%h l=%h r=%h s=%b",
                        $time, e.pose_x, e.pose_y, e.pose_heading, e.elapsed,
                        e.travel_left, e.travel_right, e.saturated);
                    $display("%0t:          actual x=%h y=%h h=%h t=%h l=%h r=%h s=%b",
                        $time, out_item.pose_x, out_item.pose_y,
                        out_item.pose_heading, out_item.elapsed,
                        out_item.travel_left, out_item.travel_right,
                        out_item.saturated);
                end
            end
            stall <= $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (stall > 0) stall <= stall - 1;
            else out_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] random_speed();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 400000)) - 200000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'(int'($urandom_range(0, 40000000)) - 20000000);
        endcase
    endfunction

    function automatic ddpu_pkg::in_item_t random_step();
        ddpu_pkg::in_item_t it;
        it.left_speed = random_speed();
        it.right_speed = $urandom_range(0, 3) == 0 ? it.left_speed : random_speed();
        if ($urandom_range(0, 7) == 0)
            it.right_speed = it.left_speed + 32'(int'($urandom_range(0, 4)) - 2);
        it.step_length = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                   : 16'($urandom_range(0, 2000));
        it.load_pose = $urandom_range(0, 15) == 0;
        it.new_x = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000);
        it.new_y = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000);
        it.new_heading = 16'($urandom);
        it.take_travel = $urandom_range(0, 3) == 0;
        return it;
    endfunction

    function automatic ddpu_pkg::in_item_t make_step(logic [31:0] vl, logic [31:0] vr,
                                           logic [15:0] dt, bit ld, logic [31:0] nx,
                                           logic [31:0] ny, logic [15:0] nh, bit tk);
        ddpu_pkg::in_item_t it;
        it.left_speed = vl; it.right_speed = vr; it.step_length = dt;
        it.load_pose = ld; it.new_x = nx; it.new_y = ny; it.new_heading = nh;
        it.take_travel = tk;
        return it;
    endfunction

    task automatic drain();
        while (step_queue.size() > 0 || pose_queue.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_offset(logic [7:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ddpu_pkg::CFG_OFFSET_ONE) m_off1 = val; else m_off2 = val;
    endtask

    // Stimulus in phases, each with its own pair of offsets.
    initial
    begin
        logic [23:0] o1[6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd1, 24'd3000, 24'hFFFFFF};
        logic [23:0] o2[6] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 24'd90000, 24'd2};
        m_x = 0; m_y = 0; m_left = 0; m_right = 0; m_time = 0; m_head = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, pose loads, travel reports, straight and turning.
        step_queue.push_back(make_step(32'h10000, 32'h10000, 16'h8000, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b1));
        step_queue.push_back(make_step(32'h10000, 32'h20000, 16'hFFFF, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b0));
        step_queue.push_back(make_step(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b1));
        step_queue.push_back(make_step(32'h80000000, 32'h80000000, 16'hFFFF, 1'b1,
                                       32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1));
        step_queue.push_back(make_step(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b1));
        step_queue.push_back(make_step(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1,
                                       32'h80000000, 32'h7FFFFFFF, 16'h4000, 1'b0));
        step_queue.push_back(make_step(32'h12345, 32'h12346, 16'd1, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b0));
        step_queue.push_back(make_step(32'h30000, 32'h50000, 16'd0, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b1));
        step_queue.push_back(make_step(32'hFFFF0000, 32'h10000, 16'h1000, 1'b1,
                                       32'd0, 32'd0, 16'h8000, 1'b0));
        step_queue.push_back(make_step(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b0));
        step_queue.push_back(make_step(32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0,
                                       32'd0, 32'd0, 16'd0, 1'b1));
        drain();

        // Random phases, each with its own pair of offsets.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_offset(ddpu_pkg::CFG_OFFSET_ONE, o1[ph]);
            write_offset(ddpu_pkg::CFG_OFFSET_TWO, o2[ph]);
            for (int k = 0; k < 255; k++) step_queue.push_back(random_step());
            // Pause once mid-phase until every result is back.
            if (ph == 2)
            begin
                while (step_queue.size() > 100) @(posedge clk);
                hold = 1'b1;
                @(posedge clk);
                while (pose_queue.size() > 0 || in_valid) @(posedge clk);
                repeat (50) @(posedge clk);
                hold = 1'b0;
            end
            drain();
        end

        $display("Ran %0d steps over 6 offset settings: %0d turning, %0d saturating.",
                 n_results, n_turns, n_sat);
        if (errors == 0)
            $display("differential_drive_pose_update verification clean");
        else
            $display("differential_drive_pose_update verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("differential_drive_pose_update verification failed");
        $finish;
    end
endmodule

[files.f]
design/ddpu_pkg.sv
design/ddpu_ctrl.sv
design/ddpu_dpath.sv
design/differential_drive_pose_update.sv
design/ddpu_checker.sv
tb/tb.sv
